/* hdl/eav_pkg.sv */
// Shared constants, types and character-class helpers for the e-mail address validator.
package eav_pkg;

   localparam int CharWidth   = 8;
   localparam int LenWidth    = 8;
   localparam int CsrIdxWidth = 8;

   typedef logic [CharWidth-1:0]   char_type;
   typedef logic [LenWidth-1:0]    len_type;
   typedef logic [CsrIdxWidth-1:0] csr_idx_type;

   // register indexes of the configuration port
   localparam csr_idx_type CSR_MIN_LENGTH = csr_idx_type'(0);
   localparam csr_idx_type CSR_MAX_LENGTH = csr_idx_type'(1);

   // reset values of the length limits
   localparam len_type MIN_LENGTH_RESET = len_type'(8);
   localparam len_type MAX_LENGTH_RESET = len_type'(60);
   localparam len_type LEN_SATURATED    = '1;

   // special characters
   localparam char_type CHAR_AT     = char_type'(8'h40);
   localparam char_type CHAR_DOT    = char_type'(8'h2e);
   localparam char_type CHAR_DASH   = char_type'(8'h2d);
   localparam char_type CHAR_UPPER_A = char_type'(8'h41);
   localparam char_type CHAR_UPPER_Z = char_type'(8'h5a);
   localparam char_type CHAR_LOWER_A = char_type'(8'h61);
   localparam char_type CHAR_LOWER_Z = char_type'(8'h7a);
   localparam char_type CHAR_DIGIT_0 = char_type'(8'h30);
   localparam char_type CHAR_DIGIT_9 = char_type'(8'h39);
   localparam char_type CASE_OFFSET  = char_type'(8'h20);

   function automatic logic is_upper(input char_type c);
      return (c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z);
   endfunction

   function automatic logic is_alnum(input char_type c);
      return is_upper(c) ||
             ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z)) ||
             ((c >= CHAR_DIGIT_0) && (c <= CHAR_DIGIT_9));
   endfunction

   function automatic logic is_joiner(input char_type c);
      return (c == CHAR_DOT) || (c == CHAR_DASH);
   endfunction

endpackage

/* hdl/eav_if.sv */
// Valid/ready channel interfaces for request, response and register writes.
interface eav_req_if;
   import eav_pkg::*;
   logic     valid;
   logic     ready;
   char_type char_in;
   logic     is_last;
   modport source (output valid, output char_in, output is_last, input ready);
   modport sink   (input valid, input char_in, input is_last, output ready);
endinterface

interface eav_rsp_if;
   import eav_pkg::*;
   logic     valid;
   logic     ready;
   char_type char_out;
   logic     end_mark;
   logic     accepted;
   modport source (output valid, output char_out, output end_mark, output accepted,
                   input ready);
   modport sink   (input valid, input char_out, input end_mark, input accepted,
                   output ready);
endinterface

interface eav_csr_if;
   import eav_pkg::*;
   logic        valid;
   logic        ready;
   csr_idx_type index;
   len_type     data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/email_address_validator_top.sv */
// Streaming e-mail address validator: one character in, one character out, verdict on the last.
//
// Takes one address character per request and returns one response per request: the same
// byte with interior letters lowercased, the last-character mark, and on the last character
// the verdict (1 = valid address). One request is taken every cycle unless the held response is stalled;
// each response appears in the response register in the cycle after its request and is
// held there while the sink stalls. Per-address state (saturating length, previous
// character, failure and '@'/'.' flags) clears after each last character. The length limits
// are written through the csr channel (index 0 = min_length, index 1 = max_length; other
// indexes are ignored) and should only be written while no address is in flight.
module email_address_validator_top (
   input  logic    clock,
   input  logic    reset,
   eav_req_if.sink   req_chan,
   eav_rsp_if.source rsp_chan,
   eav_csr_if.sink   csr_chan
);
   import eav_pkg::*;

   len_type  min_length_ff, min_length_in;
   len_type  max_length_ff, max_length_in;
   len_type  length_ff, length_in;
   char_type prev_char_ff, prev_char_in;
   logic     failed_ff, failed_in;
   logic     at_seen_ff, at_seen_in;
   logic     dot_seen_ff, dot_seen_in;

   logic     rsp_valid_ff, rsp_valid_in;
   char_type rsp_char_ff, rsp_char_in;
   logic     rsp_end_ff, rsp_end_in;
   logic     rsp_ok_ff, rsp_ok_in;

   logic     req_take;
   char_type c;
   logic     last, first, interior;
   len_type  len_next;
   logic     fail_now, fail_next, dot_next;
   char_type out_char;

   // accept whenever the response register is free or drains this cycle
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   // classify the current character
   always_comb begin
      c        = req_chan.char_in;
      last     = req_chan.is_last;
      first    = (length_ff == '0);
      interior = !first && !last;
      len_next = (length_ff == LEN_SATURATED) ? length_ff : length_ff + len_type'(1);
      fail_now = 1'b0;
      out_char = c;
      dot_next = dot_seen_ff;
      if (!first) begin
         if ((prev_char_ff == CHAR_AT) && !is_alnum(c)) begin
            fail_now = 1'b1;
         end
         if (is_joiner(prev_char_ff) && is_joiner(c)) begin
            fail_now = 1'b1;
         end
      end
      if (interior) begin
         if (c == CHAR_AT) begin
            if (!is_alnum(prev_char_ff)) begin
               fail_now = 1'b1;
            end
         end else if (c == CHAR_DOT) begin
            if (at_seen_ff) begin
               dot_next = 1'b1;
            end
         end else if (c == CHAR_DASH) begin
            // checked against the following character
         end else if (!is_alnum(c)) begin
            fail_now = 1'b1;
         end else if (is_upper(c)) begin
            out_char = c + CASE_OFFSET;
         end
      end else if (!is_alnum(c)) begin
         fail_now = 1'b1;
      end
      fail_next = failed_ff || fail_now;
   end

   // advance per-address state; clear it after the last character
   always_comb begin
      length_in    = length_ff;
      prev_char_in = prev_char_ff;
      failed_in    = failed_ff;
      at_seen_in   = at_seen_ff;
      dot_seen_in  = dot_seen_ff;
      if (req_take) begin
         if (last) begin
            length_in    = '0;
            prev_char_in = '0;
            failed_in    = 1'b0;
            at_seen_in   = 1'b0;
            dot_seen_in  = 1'b0;
         end else begin
            length_in    = len_next;
            prev_char_in = c;
            failed_in    = fail_next;
            at_seen_in   = at_seen_ff || (interior && (c == CHAR_AT));
            dot_seen_in  = dot_next;
         end
      end
   end

   // load the response register, hold it while stalled
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_char_in  = rsp_char_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_ok_in    = rsp_ok_ff;
      if (req_take) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = out_char;
         rsp_end_in   = last;
         rsp_ok_in    = last && !fail_next && dot_next &&
                        (len_next >= min_length_ff) && (len_next <= max_length_ff);
      end
   end

   // decode register writes
   always_comb begin
      min_length_in = min_length_ff;
      max_length_in = max_length_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_MIN_LENGTH: min_length_in = csr_chan.data;
            CSR_MAX_LENGTH: max_length_in = csr_chan.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_length_ff <= MIN_LENGTH_RESET;
         max_length_ff <= MAX_LENGTH_RESET;
         length_ff     <= '0;
         prev_char_ff  <= '0;
         failed_ff     <= 1'b0;
         at_seen_ff    <= 1'b0;
         dot_seen_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         min_length_ff <= min_length_in;
         max_length_ff <= max_length_in;
         length_ff     <= length_in;
         prev_char_ff  <= prev_char_in;
         failed_ff     <= failed_in;
         at_seen_ff    <= at_seen_in;
         dot_seen_ff   <= dot_seen_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_char_ff <= rsp_char_in;
      rsp_end_ff  <= rsp_end_in;
      rsp_ok_ff   <= rsp_ok_in;
   end

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.char_out = rsp_char_ff;
   assign rsp_chan.end_mark = rsp_end_ff;
   assign rsp_chan.accepted = rsp_ok_ff;

endmodule
